// File: src/brute_force_knn_top_k_unit_macros.svh
// Assertion macros shared by the k-nearest-neighbour search block.
`ifndef BRUTE_FORCE_KNN_TOP_K_UNIT_MACROS_SVH
`define BRUTE_FORCE_KNN_TOP_K_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define BFKNN_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BFKNN_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFKNN_ASSERT(lbl, clk, rst_n, prop, msg)
`define BFKNN_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

// File: src/bfknn_pkg.sv
// Shared constants, types and register codes for the k-nearest-neighbour search block.
`timescale 1ns / 1ps
package bfknn_pkg;

  localparam int unsigned MAX_DIMENSION_DEF  = 128;
  localparam int unsigned MAX_NEIGHBOURS_DEF = 16;
  localparam int unsigned ID_WIDTH_DEF       = 20;

  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned SQ_W       = 32;
  localparam int unsigned DIST_W     = 39;
  localparam int unsigned K_W        = 5;
  localparam int unsigned LEN_CFG_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [K_W-1:0]       K_RESET   = 5'd10;
  localparam logic [LEN_CFG_W-1:0] LEN_RESET = 8'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEIGHBOUR_COUNT = 1'b0,
    REG_VECTOR_LENGTH   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic vec_end;
    logic eos;
  } elem_flags_t;

endpackage

// File: src/bfknn_front.sv
// Input stage: query store, element and vector counters, query element read.
`timescale 1ns / 1ps
module bfknn_front import bfknn_pkg::*; #(
  parameter int unsigned MAX_DIMENSION = MAX_DIMENSION_DEF,
  parameter int unsigned ID_WIDTH      = ID_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [LEN_CFG_W-1:0] len_i,
  input  logic                 en_i,
  input  logic                 in_valid_i,
  input  logic                 kind_i,
  input  logic [VALUE_W-1:0]   element_value_i,
  input  logic                 end_of_set_i,
  output logic                 s1_valid_o,
  output elem_flags_t          s1_flags_o,
  output logic [VALUE_W-1:0]   s1_value_o,
  output logic [VALUE_W-1:0]   s1_query_o,
  output logic [ID_WIDTH-1:0]  s1_id_o
);

  localparam int unsigned IDX_W = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
  localparam int unsigned LEN_W = $clog2(MAX_DIMENSION + 1);
  localparam int unsigned CW    = (LEN_W > LEN_CFG_W) ? LEN_W : LEN_CFG_W;

  logic [VALUE_W-1:0]  qmem [MAX_DIMENSION];

  logic [IDX_W-1:0]    fill_q, fill_d;
  logic [IDX_W-1:0]    elem_q, elem_d;
  logic [ID_WIDTH-1:0] vcnt_q, vcnt_d;
  logic                s1_valid_q;
  elem_flags_t         s1_flags_q;
  logic [VALUE_W-1:0]  s1_value_q;
  logic [VALUE_W-1:0]  s1_query_q;
  logic [ID_WIDTH-1:0] s1_id_q;

  logic                accept;
  logic [CW-1:0]       len_ext;
  logic [CW-1:0]       len_w;
  logic [LEN_W-1:0]    len_eff;
  logic [IDX_W-1:0]    wr_addr;
  logic [LEN_W-1:0]    wr_next;
  logic [LEN_W-1:0]    elem_next;
  logic                vec_end;

  assign accept  = in_valid_i && en_i;
  assign len_ext = CW'(len_i);

  always_comb begin
    if (len_i == '0) begin
      len_w = CW'(1);
    end else if (len_ext > CW'(MAX_DIMENSION)) begin
      len_w = CW'(MAX_DIMENSION);
    end else begin
      len_w = len_ext;
    end
    len_eff = len_w[LEN_W-1:0];

    wr_addr = (LEN_W'(fill_q) >= len_eff) ? '0 : fill_q;
    wr_next = LEN_W'(wr_addr) + LEN_W'(1);
    fill_d  = (wr_next >= len_eff) ? '0 : wr_next[IDX_W-1:0];

    elem_next = LEN_W'(elem_q) + LEN_W'(1);
    vec_end   = (elem_next >= len_eff) || end_of_set_i;
    elem_d    = vec_end ? '0 : elem_next[IDX_W-1:0];
    if (end_of_set_i) begin
      vcnt_d = '0;
    end else if (vec_end) begin
      vcnt_d = vcnt_q + ID_WIDTH'(1);
    end else begin
      vcnt_d = vcnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      elem_q     <= '0;
      vcnt_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (en_i) begin
        s1_valid_q <= accept && kind_i;
      end
      if (accept && !kind_i) begin
        fill_q <= fill_d;
      end
      if (accept && kind_i) begin
        elem_q <= elem_d;
        vcnt_q <= vcnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !kind_i) begin
      qmem[wr_addr] <= element_value_i;
    end
    if (accept && kind_i) begin
      s1_query_q <= qmem[elem_q];
      s1_value_q <= element_value_i;
      s1_flags_q <= '{vec_end: vec_end, eos: end_of_set_i};
      s1_id_q    <= vcnt_q;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_flags_o = s1_flags_q;
  assign s1_value_o = s1_value_q;
  assign s1_query_o = s1_query_q;
  assign s1_id_o    = s1_id_q;

endmodule

// File: src/bfknn_dist.sv
// Distance datapath: difference and square, then saturating accumulation per vector.
`timescale 1ns / 1ps
module bfknn_dist import bfknn_pkg::*; #(
  parameter int unsigned ID_WIDTH = ID_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                s1_valid_i,
  input  elem_flags_t         s1_flags_i,
  input  logic [VALUE_W-1:0]  s1_value_i,
  input  logic [VALUE_W-1:0]  s1_query_i,
  input  logic [ID_WIDTH-1:0] s1_id_i,
  output logic                cand_valid_o,
  output elem_flags_t         cand_flags_o,
  output logic [ID_WIDTH-1:0] cand_id_o,
  output logic [DIST_W-1:0]   cand_dist_o
);

  logic                s2_valid_q;
  elem_flags_t         s2_flags_q;
  logic [SQ_W-1:0]     s2_sq_q;
  logic [ID_WIDTH-1:0] s2_id_q;

  logic [DIST_W-1:0]   acc_q, acc_d;
  logic                cand_valid_q;
  elem_flags_t         cand_flags_q;
  logic [ID_WIDTH-1:0] cand_id_q;
  logic [DIST_W-1:0]   cand_dist_q;

  logic signed [VALUE_W:0] diff;
  logic [VALUE_W:0]        neg;
  logic [VALUE_W-1:0]      mag;
  logic [SQ_W-1:0]         sq;
  logic [DIST_W:0]         sum;
  logic [DIST_W-1:0]       sat;

  always_comb begin
    diff = $signed({s1_value_i[VALUE_W-1], s1_value_i})
         - $signed({s1_query_i[VALUE_W-1], s1_query_i});
    neg  = -diff;
    mag  = diff[VALUE_W] ? neg[VALUE_W-1:0] : diff[VALUE_W-1:0];
    sq   = SQ_W'(mag) * SQ_W'(mag);

    sum  = {1'b0, acc_q} + (DIST_W + 1)'(s2_sq_q);
    sat  = sum[DIST_W] ? {DIST_W{1'b1}} : sum[DIST_W-1:0];
    acc_d = s2_flags_q.vec_end ? '0 : sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q   <= 1'b0;
      cand_valid_q <= 1'b0;
      acc_q        <= '0;
    end else if (en_i) begin
      s2_valid_q   <= s1_valid_i;
      cand_valid_q <= s2_valid_q && s2_flags_q.vec_end;
      if (s2_valid_q) begin
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && s1_valid_i) begin
      s2_sq_q    <= sq;
      s2_flags_q <= s1_flags_i;
      s2_id_q    <= s1_id_i;
    end
    if (en_i && s2_valid_q && s2_flags_q.vec_end) begin
      cand_dist_q  <= sat;
      cand_flags_q <= s2_flags_q;
      cand_id_q    <= s2_id_q;
    end
  end

  assign cand_valid_o = cand_valid_q;
  assign cand_flags_o = cand_flags_q;
  assign cand_id_o    = cand_id_q;
  assign cand_dist_o  = cand_dist_q;

endmodule

// File: src/bfknn_topk.sv
// Sorted top-k list with parallel-compare insert and the result shift buffer.
`timescale 1ns / 1ps
`include "brute_force_knn_top_k_unit_macros.svh"
module bfknn_topk import bfknn_pkg::*; #(
  parameter int unsigned MAX_NEIGHBOURS = MAX_NEIGHBOURS_DEF,
  parameter int unsigned ID_WIDTH       = ID_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [K_W-1:0]      k_i,
  input  logic                cand_valid_i,
  input  elem_flags_t         cand_flags_i,
  input  logic [ID_WIDTH-1:0] cand_id_i,
  input  logic [DIST_W-1:0]   cand_dist_i,
  output logic                en_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ID_WIDTH-1:0] vector_id_o,
  output logic [DIST_W-1:0]   squared_distance_o,
  output logic                last_result_o
);

  localparam int unsigned FILL_W = $clog2(MAX_NEIGHBOURS + 1);
  localparam int unsigned CW     = (FILL_W > K_W) ? FILL_W : K_W;

  logic [ID_WIDTH-1:0] ids_q  [MAX_NEIGHBOURS];
  logic [DIST_W-1:0]   dist_q [MAX_NEIGHBOURS];
  logic [ID_WIDTH-1:0] ids_n  [MAX_NEIGHBOURS];
  logic [DIST_W-1:0]   dist_n [MAX_NEIGHBOURS];
  logic [ID_WIDTH-1:0] buf_ids_q  [MAX_NEIGHBOURS];
  logic [DIST_W-1:0]   buf_dist_q [MAX_NEIGHBOURS];

  logic [FILL_W-1:0]   fill_q;
  logic [FILL_W-1:0]   out_cnt_q;
  logic [FILL_W-1:0]   fill_c, fill_n, cap;
  logic [CW-1:0]       k_ext, cap_w;
  logic [MAX_NEIGHBOURS-1:0] le;
  logic                en, insert, out_take;

  assign en       = !(cand_valid_i && cand_flags_i.eos && (out_cnt_q != '0));
  assign insert   = cand_valid_i && en;
  assign out_take = (out_cnt_q != '0) && !out_stall_i;
  assign k_ext    = CW'(k_i);

  always_comb begin
    if (k_i == '0) begin
      cap_w = CW'(1);
    end else if (k_ext > CW'(MAX_NEIGHBOURS)) begin
      cap_w = CW'(MAX_NEIGHBOURS);
    end else begin
      cap_w = k_ext;
    end
    cap    = cap_w[FILL_W-1:0];
    fill_c = (fill_q > cap) ? cap : fill_q;
    fill_n = (fill_c < cap) ? fill_c + FILL_W'(1) : fill_c;

    for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
      le[i] = (FILL_W'(i) < fill_c) && (dist_q[i] <= cand_dist_i);
    end

    // entries ahead of the new one stay, the rest move down by one
    ids_n[0]  = le[0] ? ids_q[0]  : cand_id_i;
    dist_n[0] = le[0] ? dist_q[0] : cand_dist_i;
    for (int i = 1; i < MAX_NEIGHBOURS; i++) begin
      if (le[i]) begin
        ids_n[i]  = ids_q[i];
        dist_n[i] = dist_q[i];
      end else if (le[i-1]) begin
        ids_n[i]  = cand_id_i;
        dist_n[i] = cand_dist_i;
      end else begin
        ids_n[i]  = ids_q[i-1];
        dist_n[i] = dist_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      out_cnt_q <= '0;
    end else begin
      if (insert) begin
        fill_q <= cand_flags_i.eos ? '0 : fill_n;
      end
      if (insert && cand_flags_i.eos) begin
        out_cnt_q <= fill_n;
      end else if (out_take) begin
        out_cnt_q <= out_cnt_q - FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (insert) begin
      ids_q  <= ids_n;
      dist_q <= dist_n;
    end
    if (insert && cand_flags_i.eos) begin
      buf_ids_q  <= ids_n;
      buf_dist_q <= dist_n;
    end else if (out_take) begin
      for (int i = 0; i < MAX_NEIGHBOURS - 1; i++) begin
        buf_ids_q[i]  <= buf_ids_q[i+1];
        buf_dist_q[i] <= buf_dist_q[i+1];
      end
    end
  end

  assign en_o               = en;
  assign out_valid_o        = (out_cnt_q != '0);
  assign vector_id_o        = buf_ids_q[0];
  assign squared_distance_o = buf_dist_q[0];
  assign last_result_o      = (out_cnt_q == FILL_W'(1));

  `BFKNN_ASSERT(a_cnt_max, clk_i, rst_ni, out_cnt_q <= FILL_W'(MAX_NEIGHBOURS), "result count overrun")
  `BFKNN_ASSERT(a_hold_busy, clk_i, rst_ni, !en |-> out_cnt_q != '0, "hold without pending results")
  `BFKNN_ASSERT(a_last_empty, clk_i, rst_ni, out_take && last_result_o |=> out_cnt_q == '0, "results after last")
  `BFKNN_ASSERT(a_ins_fill, clk_i, rst_ni, insert && !cand_flags_i.eos |=> fill_q != '0, "insert lost")
  `BFKNN_ASSERT_NORST(a_rst_empty, clk_i, !rst_ni |=> out_cnt_q == '0, "results during reset")

endmodule

// File: src/brute_force_knn_top_k_unit.sv
// Output: the end-of-set transaction passes s1, s2 and the candidate register into the
// result buffer; results go one per cycle if not stalled, last flagged by last_result_o.
// Throughput: one input transaction per cycle; the input stalls only while an end-of-set
// transaction reaches the list with the previous result set still draining.
// Reset: counters, list fill and result count clear; k = 10, length = 128; the query
// store and the result buffer contents are not cleared.
`timescale 1ns / 1ps
module brute_force_knn_top_k_unit import bfknn_pkg::*; #(
  parameter int unsigned MAX_DIMENSION  = MAX_DIMENSION_DEF,
  parameter int unsigned MAX_NEIGHBOURS = MAX_NEIGHBOURS_DEF,
  parameter int unsigned ID_WIDTH       = ID_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  kind_i,
  input  logic [VALUE_W-1:0]    element_value_i,
  input  logic                  end_of_set_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ID_WIDTH-1:0]   vector_id_o,
  output logic [DIST_W-1:0]     squared_distance_o,
  output logic                  last_result_o
);

  logic [K_W-1:0]       k_q;
  logic [LEN_CFG_W-1:0] len_q;
  logic                 en;

  logic                 s1_valid;
  elem_flags_t          s1_flags;
  logic [VALUE_W-1:0]   s1_value;
  logic [VALUE_W-1:0]   s1_query;
  logic [ID_WIDTH-1:0]  s1_id;

  logic                 cand_valid;
  elem_flags_t          cand_flags;
  logic [ID_WIDTH-1:0]  cand_id;
  logic [DIST_W-1:0]    cand_dist;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= K_RESET;
      len_q <= LEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_NEIGHBOUR_COUNT: k_q   <= cfg_data_i[K_W-1:0];
        REG_VECTOR_LENGTH:   len_q <= cfg_data_i[LEN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = !en;

  bfknn_front #(
    .MAX_DIMENSION (MAX_DIMENSION),
    .ID_WIDTH      (ID_WIDTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .len_i           (len_q),
    .en_i            (en),
    .in_valid_i      (in_valid_i),
    .kind_i          (kind_i),
    .element_value_i (element_value_i),
    .end_of_set_i    (end_of_set_i),
    .s1_valid_o      (s1_valid),
    .s1_flags_o      (s1_flags),
    .s1_value_o      (s1_value),
    .s1_query_o      (s1_query),
    .s1_id_o         (s1_id)
  );

  bfknn_dist #(
    .ID_WIDTH (ID_WIDTH)
  ) u_dist (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .s1_valid_i   (s1_valid),
    .s1_flags_i   (s1_flags),
    .s1_value_i   (s1_value),
    .s1_query_i   (s1_query),
    .s1_id_i      (s1_id),
    .cand_valid_o (cand_valid),
    .cand_flags_o (cand_flags),
    .cand_id_o    (cand_id),
    .cand_dist_o  (cand_dist)
  );

  bfknn_topk #(
    .MAX_NEIGHBOURS (MAX_NEIGHBOURS),
    .ID_WIDTH       (ID_WIDTH)
  ) u_topk (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .k_i                (k_q),
    .cand_valid_i       (cand_valid),
    .cand_flags_i       (cand_flags),
    .cand_id_i          (cand_id),
    .cand_dist_i        (cand_dist),
    .en_o               (en),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .vector_id_o        (vector_id_o),
    .squared_distance_o (squared_distance_o),
    .last_result_o      (last_result_o)
  );

endmodule

// File: dv/brute_force_knn_top_k_unit_test.sv
// Self-checking testbench for the brute-force k-nearest-neighbour search block.
`timescale 1ns / 1ps
module brute_force_knn_top_k_unit_test;
  import bfknn_pkg::*;

  localparam logic KIND_QUERY    = 1'b0;
  localparam logic KIND_DATABASE = 1'b1;

  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_ITEMS  = 310;
  localparam longint unsigned DIST_LIMIT = (64'd1 << DIST_W) - 64'd1;

  typedef struct {
    logic               kind;
    logic [VALUE_W-1:0] value;
    logic               eos;
  } element_t;

  typedef struct packed {
    logic [ID_WIDTH_DEF-1:0] id;
    logic [DIST_W-1:0]       sq_dist;
    logic                    last;
  } neighbour_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = REG_NEIGHBOUR_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic kind_i = KIND_QUERY;
  logic [VALUE_W-1:0] element_value_i = '0;
  logic end_of_set_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [ID_WIDTH_DEF-1:0] vector_id_o;
  logic [DIST_W-1:0] squared_distance_o;
  logic last_result_o;

  brute_force_knn_top_k_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .kind_i             (kind_i),
    .element_value_i    (element_value_i),
    .end_of_set_i       (end_of_set_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .vector_id_o        (vector_id_o),
    .squared_distance_o (squared_distance_o),
    .last_result_o      (last_result_o)
  );

  always #6 clk_i = ~clk_i;

  // search state mirrored by the predictor
  logic [VALUE_W-1:0]      query_store [MAX_DIMENSION_DEF];
  int unsigned             query_fill;
  int unsigned             element_pos;
  longint unsigned         dist_acc;
  logic [ID_WIDTH_DEF-1:0] vector_count;
  logic [ID_WIDTH_DEF-1:0] best_id   [MAX_NEIGHBOURS_DEF];
  longint unsigned         best_dist [MAX_NEIGHBOURS_DEF];
  int unsigned             best_fill;
  logic [K_W-1:0]          k_reg;
  logic [LEN_CFG_W-1:0]    len_reg;

  element_t   pending_elements[$];
  neighbour_t expected_neighbours[$];
  element_t   next_elem;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_arm = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned queued_total = 0;

  function automatic int unsigned clamp_k();
    if (k_reg < 1) return 1;
    if (k_reg > MAX_NEIGHBOURS_DEF) return MAX_NEIGHBOURS_DEF;
    return k_reg;
  endfunction

  function automatic int unsigned clamp_len();
    if (len_reg < 1) return 1;
    if (len_reg > MAX_DIMENSION_DEF) return MAX_DIMENSION_DEF;
    return len_reg;
  endfunction

  task automatic rank_insert(logic [ID_WIDTH_DEF-1:0] id, longint unsigned cand_dist);
    int unsigned cap, pos, i;
    cap = clamp_k();
    pos = 0;
    if (best_fill > cap) best_fill = cap;
    while (pos < best_fill && best_dist[pos] <= cand_dist) pos++;
    if (pos >= cap) return;
    i = (best_fill < cap) ? best_fill : cap - 1;
    while (i > pos) begin
      best_id[i]   = best_id[i-1];
      best_dist[i] = best_dist[i-1];
      i--;
    end
    best_id[pos]   = id;
    best_dist[pos] = cand_dist;
    if (best_fill < cap) best_fill++;
  endtask

  task automatic absorb_element(logic kind, logic [VALUE_W-1:0] value, logic eos);
    int unsigned len, n, i;
    int diff;
    longint unsigned sq;
    neighbour_t nb;
    len = clamp_len();
    if (kind == KIND_QUERY) begin
      if (query_fill >= len) query_fill = 0;
      query_store[query_fill] = value;
      query_fill++;
      if (query_fill >= len) query_fill = 0;
      return;
    end
    if (element_pos >= MAX_DIMENSION_DEF) element_pos = MAX_DIMENSION_DEF - 1;
    diff = int'($signed(value)) - int'($signed(query_store[element_pos]));
    if (diff < 0) diff = -diff;
    sq = longint'(diff) * longint'(diff);
    dist_acc += sq;
    if (dist_acc > DIST_LIMIT) dist_acc = DIST_LIMIT;
    if (element_pos + 1 >= len || eos) begin
      rank_insert(vector_count, dist_acc);
      vector_count++;
      dist_acc = 0;
      element_pos = 0;
    end else begin
      element_pos++;
    end
    if (!eos) return;
    n = (best_fill < clamp_k()) ? best_fill : clamp_k();
    for (i = 0; i < n; i++) begin
      nb.id      = best_id[i];
      nb.sq_dist = best_dist[i][DIST_W-1:0];
      nb.last    = (i + 1 == n);
      expected_neighbours.insert(expected_neighbours.size(), nb);
    end
    best_fill = 0;
    vector_count = '0;
    element_pos = 0;
    dist_acc = 0;
  endtask

  // driver: presents queued elements, predicts on each accepted transaction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) absorb_element(kind_i, element_value_i, end_of_set_i);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_elements.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_elem = pending_elements.pop_front();
          in_valid_i      <= 1'b1;
          kind_i          <= next_elem.kind;
          element_value_i <= next_elem.value;
          end_of_set_i    <= next_elem.eos;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure, with one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_arm) begin
      hold_taken <= hold_arm;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_neighbours.size() == 0) begin
        $error("unexpected result transaction: vector_id %0d, squared_distance %0d",
               vector_id_o, squared_distance_o);
        mismatches++;
      end else begin
        if (vector_id_o !== expected_neighbours[0].id) begin
          $error("vector_id: expected %0d, actual %0d", expected_neighbours[0].id,
                 vector_id_o);
          mismatches++;
        end
        if (squared_distance_o !== expected_neighbours[0].sq_dist) begin
          $error("squared_distance: expected %0d, actual %0d",
                 expected_neighbours[0].sq_dist, squared_distance_o);
          mismatches++;
        end
        if (last_result_o !== expected_neighbours[0].last) begin
          $error("last_result: expected %0d, actual %0d", expected_neighbours[0].last,
                 last_result_o);
          mismatches++;
        end
        void'(expected_neighbours.pop_front());
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("brute_force_knn_top_k_unit_test: done, errors");
    $finish;
  end

  task automatic queue_element(logic kind, logic [VALUE_W-1:0] value, logic eos);
    element_t el;
    el.kind  = kind;
    el.value = value;
    el.eos   = eos;
    pending_elements.insert(pending_elements.size(), el);
    queued_total++;
  endtask

  task automatic settle();
    while (pending_elements.size() != 0 || in_valid_i || expected_neighbours.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_NEIGHBOUR_COUNT) k_reg = data[K_W-1:0];
    else len_reg = data;
  endtask

  function automatic logic [VALUE_W-1:0] rand_element();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(8)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_k();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd16;
      3: return 8'd31;
      4: return 8'($urandom);
      default: return 8'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_len();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd128;
      2: return 8'd255;
      default: return 8'($urandom_range(1, 6));
    endcase
  endfunction

  // one set of database vectors; may end early or stay open for the next phase
  task automatic queue_set(int unsigned len);
    int unsigned vectors, span, v, e, shape;
    logic last;
    shape = $urandom_range(9);
    vectors = $urandom_range(1, 20);
    span = len;
    if (len > 16) begin
      vectors = 1;
      span = $urandom_range(1, 10);
      shape = 2;
    end
    for (v = 0; v < vectors; v++) begin
      for (e = 0; e < span; e++) begin
        if ($urandom_range(19) == 0) queue_element(KIND_QUERY, rand_element(), $urandom_range(1));
        last = (v == vectors - 1) && (e == span - 1);
        if (shape == 1 && !last && $urandom_range(24) == 0) begin
          queue_element(KIND_DATABASE, rand_element(), 1'b1);
          return;
        end
        queue_element(KIND_DATABASE, rand_element(), last && shape != 0);
      end
    end
  endtask

  initial begin
    int unsigned i, n, base, done, len;
    bit pressured;
    query_fill = 0;
    element_pos = 0;
    dist_acc = 0;
    vector_count = '0;
    best_fill = 0;
    k_reg = K_RESET;
    len_reg = LEN_RESET;
    pressured = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full query load at the reset length, wrapping the fill position
    queue_element(KIND_QUERY, 16'h7FFF, 1'b0);
    queue_element(KIND_QUERY, 16'h8000, 1'b1);
    queue_element(KIND_QUERY, 16'h0000, 1'b0);
    queue_element(KIND_QUERY, 16'hFFFF, 1'b0);
    for (i = 4; i < MAX_DIMENSION_DEF; i++)
      queue_element(KIND_QUERY, rand_element(), $urandom_range(1));

    // k below range, short vectors, tie on distance keeps the earlier id
    settle();
    write_register(REG_NEIGHBOUR_COUNT, 8'd0);
    write_register(REG_VECTOR_LENGTH, 8'd3);
    queue_element(KIND_QUERY, 16'h7FFF, 1'b0);
    queue_element(KIND_QUERY, 16'h8000, 1'b1);
    queue_element(KIND_QUERY, 16'h0000, 1'b0);
    queue_element(KIND_DATABASE, 16'h8000, 1'b0);
    queue_element(KIND_DATABASE, 16'h7FFF, 1'b0);
    queue_element(KIND_DATABASE, 16'hFFFF, 1'b0);
    queue_element(KIND_DATABASE, 16'h7FFF, 1'b0);
    queue_element(KIND_DATABASE, 16'h8000, 1'b0);
    queue_element(KIND_DATABASE, 16'h0000, 1'b0);
    queue_element(KIND_DATABASE, 16'h7FFF, 1'b0);
    queue_element(KIND_DATABASE, 16'h8000, 1'b0);
    queue_element(KIND_DATABASE, 16'h0000, 1'b1);

    // k above range, zero length clamps to one element per vector
    settle();
    write_register(REG_NEIGHBOUR_COUNT, 8'd31);
    write_register(REG_VECTOR_LENGTH, 8'd0);
    queue_element(KIND_DATABASE, 16'h8000, 1'b0);
    queue_element(KIND_DATABASE, 16'h7FFF, 1'b0);
    queue_element(KIND_DATABASE, 16'h1234, 1'b0);
    queue_element(KIND_DATABASE, 16'h7FFF, 1'b1);

    // length above range, set closed early with a partial vector
    settle();
    write_register(REG_NEIGHBOUR_COUNT, 8'd16);
    write_register(REG_VECTOR_LENGTH, 8'd255);
    for (i = 0; i < 5; i++) queue_element(KIND_DATABASE, 16'h8000 ^ 16'(i), i == 4);

    base = queued_total;
    while (queued_total - base < RANDOM_ITEMS || !pressured) begin
      done = queued_total - base;
      settle();
      if (done < 100) begin
        send_idle_pct <= 12;
        recv_idle_pct <= 56;
      end else if (done < 200) begin
        send_idle_pct <= 56;
        recv_idle_pct <= 12;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      if (!pressured && done >= 200) begin
        // long receiver hold-off while short sets keep arriving
        pressured = 1'b1;
        write_register(REG_VECTOR_LENGTH, 8'd1);
        hold_arm <= hold_arm + 1;
        for (i = 0; i < 12; i++) begin
          queue_element(KIND_DATABASE, rand_element(), 1'b0);
          queue_element(KIND_DATABASE, rand_element(), 1'b1);
        end
      end else begin
        if ($urandom_range(3) != 0) write_register(REG_NEIGHBOUR_COUNT, pick_k());
        if ($urandom_range(3) != 0) write_register(REG_VECTOR_LENGTH, pick_len());
        len = clamp_len();
        if ($urandom_range(2) == 0) begin
          n = (len > 16) ? $urandom_range(1, 8) : len;
          for (i = 0; i < n; i++) queue_element(KIND_QUERY, rand_element(), $urandom_range(1));
        end
        queue_set(len);
      end
    end

    // close any set left open so its results are drained too
    settle();
    queue_element(KIND_DATABASE, rand_element(), 1'b1);
    settle();
    if (mismatches == 0) $display("brute_force_knn_top_k_unit_test: done, clean");
    else $display("brute_force_knn_top_k_unit_test: done, errors");
    $finish;
  end

endmodule
